// File: sv/lbf_pkg.sv
// lbf_pkg: shared types, constants and command/status structs for the learning bridge
// depends on nothing
`timescale 1ns / 1ps

package lbf_pkg;

   localparam int TableEntries  = 64;
   localparam int NumPorts      = 8;
   localparam int IdxW          = $clog2(TableEntries);
   localparam int CntW          = $clog2(TableEntries + 1);
   localparam int MacW          = 48;
   localparam int PortW         = 3;
   localparam int TimeW         = 32;
   localparam int MaskW         = 8;
   localparam int GroupBit      = 40;
   localparam logic [31:0] DefaultExpiry = 32'd300;

   // ports that can exist on this build
   localparam logic [MaskW-1:0] UsableLim = MaskW'((64'd1 << NumPorts) - 64'd1);

   // register addresses (byte address / 8)
   localparam logic [1:0] RegLearnEn = 2'd0;
   localparam logic [1:0] RegExpiry  = 2'd1;
   localparam logic [1:0] RegBridge  = 2'd2;
   localparam logic [1:0] RegPorts   = 2'd3;

   // frame kinds
   localparam logic [1:0] KindHost  = 2'd0;
   localparam logic [1:0] KindBcast = 2'd1;
   localparam logic [1:0] KindMcast = 2'd2;
   localparam logic [1:0] KindOther = 2'd3;

   typedef struct packed {
      logic capture;     // latch the transaction
      logic scan_start;  // restart the table scan
      logic scan_step;   // advance the scan by one entry
      logic finish;      // apply learn / erase and form the result
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

// File: sv/lbf_if.sv
// lbf_if: valid/ready channel carrying a payload of generic type
// depends on nothing
`timescale 1ns / 1ps

interface lbf_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/learning_bridge_forwarder_top.sv
// learning_bridge_forwarder_top: learning bridge with aging mac table
// depends on lbf_pkg, lbf_if, lbf_ctrl, lbf_datapath, lbf_csr

`timescale 1ns / 1ps

// Each request transaction is answered after a table scan and a finish step:
// the 64-entry mac table is a single-port memory scanned one entry a cycle
// through a registered read, which finds the source match, destination match,
// first free entry and soonest expiry in one pass; learn, erase and the
// forwarding decision follow in the finish step, which waits for the output
// register to be free. The response sits in an output register and the next
// request is taken in the cycle it leaves, so transactions never overlap. Table
// valid bits clear at reset, no sweep.

module learning_bridge_forwarder_top (
   input  logic        clock,
   input  logic        reset,
   lbf_if.sink         req,
   lbf_if.source       rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   lbf_pkg::cmd_type    cmd;
   lbf_pkg::status_type status;
   logic        learn_en;
   logic [31:0] expiry_ticks;
   logic [47:0] bridge_mac;
   logic [7:0]  port_mask;

   assign csr_pready = 1'b1;

   lbf_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .learn_en, .expiry_ticks, .bridge_mac, .port_mask
   );

   lbf_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .status, .cmd
   );

   lbf_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_cmd(req.data.cmd), .req_src_mac(req.data.src_mac),
      .req_dst_mac(req.data.dst_mac), .req_in_port(req.data.in_port),
      .req_frame_kind(req.data.frame_kind), .req_now(req.data.now),
      .learn_en, .expiry_ticks, .bridge_mac, .port_mask,
      .rsp_deliver_up(rsp.data.deliver_up),
      .rsp_tx_port_mask(rsp.data.tx_port_mask),
      .rsp_flooded(rsp.data.flooded)
   );

endmodule

// File: sv/lbf_ctrl.sv
// lbf_ctrl: controller state machine for the learning bridge
// depends on lbf_pkg
`timescale 1ns / 1ps

module lbf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   input  lbf_pkg::status_type status,
   output lbf_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH, ST_HOLD} state_type;
   state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   // accept a new transaction when idle and the output slot is free or leaving
   assign in_ready  = (state_ff == ST_IDLE) && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      if (out_valid_ff && out_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid && in_ready) begin
               cmd.capture    = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || out_ready) begin
               cmd.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_HOLD: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: sv/lbf_datapath.sv
// lbf_datapath: mac table memory, sequential scan and forwarding decision
// depends on lbf_pkg
`timescale 1ns / 1ps

module lbf_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lbf_pkg::cmd_type             cmd,
   output lbf_pkg::status_type          status,
   input  logic                         req_cmd,
   input  logic [lbf_pkg::MacW-1:0]     req_src_mac,
   input  logic [lbf_pkg::MacW-1:0]     req_dst_mac,
   input  logic [lbf_pkg::PortW-1:0]    req_in_port,
   input  logic [1:0]                   req_frame_kind,
   input  logic [lbf_pkg::TimeW-1:0]    req_now,
   input  logic                         learn_en,
   input  logic [lbf_pkg::TimeW-1:0]    expiry_ticks,
   input  logic [lbf_pkg::MacW-1:0]     bridge_mac,
   input  logic [lbf_pkg::MaskW-1:0]    port_mask,
   output logic                         rsp_deliver_up,
   output logic [lbf_pkg::MaskW-1:0]    rsp_tx_port_mask,
   output logic                         rsp_flooded
);

   localparam int N  = lbf_pkg::TableEntries;
   localparam int IW = lbf_pkg::IdxW;
   localparam int CW = lbf_pkg::CntW;

   // table storage; valid bits in flip-flops, payload in a memory
   logic [N-1:0]                 valid_ff, valid_in;
   logic [lbf_pkg::MacW-1:0]     mac_mem [N];
   logic [lbf_pkg::PortW-1:0]    port_mem [N];
   logic [lbf_pkg::TimeW-1:0]    exp_mem [N];

   // captured transaction
   logic                         cmd_ff;
   logic [lbf_pkg::MacW-1:0]     src_ff, dst_ff;
   logic [lbf_pkg::PortW-1:0]    inp_ff;
   logic [1:0]                   kind_ff;
   logic [lbf_pkg::TimeW-1:0]    now_ff;

   // scan state
   logic [CW-1:0]                cnt_ff;       // address issued
   logic                         rd_vld_ff;    // read data belongs to entry idx_ff
   logic [IW-1:0]                idx_ff;
   logic [lbf_pkg::MacW-1:0]     rd_mac_ff;
   logic [lbf_pkg::PortW-1:0]    rd_port_ff;
   logic [lbf_pkg::TimeW-1:0]    rd_exp_ff;
   logic                         src_hit_ff, dst_hit_ff, free_ff;
   logic [IW-1:0]                src_idx_ff, dst_idx_ff, free_idx_ff, min_idx_ff;
   logic [lbf_pkg::PortW-1:0]    dst_port_ff;
   logic [lbf_pkg::TimeW-1:0]    dst_exp_ff, min_exp_ff;
   logic                         min_set_ff;

   logic                         up_ff, fl_ff;
   logic [lbf_pkg::MaskW-1:0]    tx_ff;
   logic                         up_in, fl_in;
   logic [lbf_pkg::MaskW-1:0]    tx_in;

   assign status.scan_done = (cnt_ff == CW'(N)) && !rd_vld_ff;
   assign rsp_deliver_up   = up_ff;
   assign rsp_tx_port_mask = tx_ff;
   assign rsp_flooded      = fl_ff;

   // decision terms
   logic [lbf_pkg::MaskW-1:0] ports, others;
   logic                      learn_act, dst_live, dst_use, do_look;
   logic                      src_eq, dst_gone, keep_new, erase_dst;
   logic [IW-1:0]             slot;
   logic [lbf_pkg::TimeW:0]   exp_sum;
   logic [lbf_pkg::TimeW-1:0] exp_new;
   logic                      v_vld, s_m, d_m;

   always_comb begin
      ports     = port_mask & lbf_pkg::UsableLim;
      others    = ports & ~(lbf_pkg::MaskW'(1) << inp_ff);
      exp_sum   = {1'b0, now_ff} + {1'b0, expiry_ticks};
      exp_new   = exp_sum[lbf_pkg::TimeW] ? '1 : exp_sum[lbf_pkg::TimeW-1:0];
      learn_act = learn_en && !cmd_ff &&
                  ((kind_ff == lbf_pkg::KindBcast) || (kind_ff == lbf_pkg::KindMcast) ||
                   (dst_ff == bridge_mac) || (kind_ff == lbf_pkg::KindOther));
      slot      = src_hit_ff ? src_idx_ff : (free_ff ? free_idx_ff : min_idx_ff);
      do_look   = learn_en && (cmd_ff ? !dst_ff[lbf_pkg::GroupBit] :
                  ((kind_ff == lbf_pkg::KindOther) && (dst_ff != bridge_mac)));
      // lookup follows learn: a dst equal to src finds the fresh entry,
      // a dst entry replaced by the learn is no longer there
      src_eq    = learn_act && (src_ff == dst_ff);
      dst_gone  = learn_act && dst_hit_ff && (slot == dst_idx_ff) && !src_eq;
      if (src_eq) begin
         dst_live = exp_new > now_ff;
      end else begin
         dst_live = dst_hit_ff && !dst_gone && (dst_exp_ff > now_ff);
      end
      dst_use   = do_look && dst_live;
      // fresh entry that is already stale at its own lookup is erased
      keep_new  = !(do_look && src_eq && !(exp_new > now_ff));
      // stale dst entry is erased unless the learn just took its slot
      erase_dst = do_look && dst_hit_ff && !(dst_exp_ff > now_ff) &&
                  !(learn_act && slot == dst_idx_ff);
      v_vld = rd_vld_ff && valid_ff[idx_ff];
      s_m   = v_vld && (rd_mac_ff == src_ff);
      d_m   = v_vld && (rd_mac_ff == dst_ff);
   end

   logic [lbf_pkg::PortW-1:0] use_port;
   always_comb begin
      // src == dst after learn gives in_port
      use_port = (!cmd_ff && learn_act && src_ff == dst_ff) ? inp_ff : dst_port_ff;
   end

   // forwarding decision
   always_comb begin
      up_in = 1'b0;
      tx_in = '0;
      fl_in = 1'b0;
      if (cmd_ff) begin
         if (dst_use && ports[use_port]) begin
            tx_in = lbf_pkg::MaskW'(1) << use_port;
         end else begin
            tx_in = ports;
            fl_in = 1'b1;
         end
      end else if (kind_ff == lbf_pkg::KindBcast || kind_ff == lbf_pkg::KindMcast) begin
         up_in = 1'b1;
         tx_in = others;
         fl_in = 1'b1;
      end else if (dst_ff == bridge_mac) begin
         up_in = 1'b1;
      end else if (kind_ff == lbf_pkg::KindOther) begin
         if (dst_use && use_port != inp_ff && ports[use_port]) begin
            tx_in = lbf_pkg::MaskW'(1) << use_port;
         end else begin
            tx_in = others;
            fl_in = 1'b1;
         end
      end
   end

   // next valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         if (erase_dst) valid_in[dst_idx_ff] = 1'b0;
         if (learn_act) valid_in[slot] = keep_new;
      end
   end

   always_ff @(posedge clock) begin
      // capture
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         src_ff  <= req_src_mac;
         dst_ff  <= req_dst_mac;
         inp_ff  <= req_in_port;
         kind_ff <= req_frame_kind;
         now_ff  <= req_now;
      end
      // registered memory read
      if (cnt_ff < CW'(N)) begin
         rd_mac_ff  <= mac_mem[cnt_ff[IW-1:0]];
         rd_port_ff <= port_mem[cnt_ff[IW-1:0]];
         rd_exp_ff  <= exp_mem[cnt_ff[IW-1:0]];
      end
      idx_ff <= cnt_ff[IW-1:0];
      // scan accumulate, first hit wins
      if (cmd.scan_start) begin
         src_hit_ff <= 1'b0;
         dst_hit_ff <= 1'b0;
         free_ff    <= 1'b0;
         min_set_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (s_m && !src_hit_ff) begin
            src_hit_ff <= 1'b1;
            src_idx_ff <= idx_ff;
         end
         if (d_m && !dst_hit_ff) begin
            dst_hit_ff  <= 1'b1;
            dst_idx_ff  <= idx_ff;
            dst_port_ff <= rd_port_ff;
            dst_exp_ff  <= rd_exp_ff;
         end
         if (!valid_ff[idx_ff] && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (v_vld && (!min_set_ff || rd_exp_ff < min_exp_ff)) begin
            min_set_ff <= 1'b1;
            min_exp_ff <= rd_exp_ff;
            min_idx_ff <= idx_ff;
         end
      end
      // learn write
      if (cmd.finish && learn_act) begin
         mac_mem[slot]  <= src_ff;
         port_mem[slot] <= inp_ff;
         exp_mem[slot]  <= exp_new;
      end
      // result
      if (cmd.finish) begin
         up_ff <= up_in;
         tx_ff <= tx_in;
         fl_ff <= fl_in;
      end
   end

   // control registers: scan counter and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= CW'(N);
         rd_vld_ff <= 1'b0;
         valid_ff  <= '0;
      end else begin
         rd_vld_ff <= cmd.scan_step && (cnt_ff < CW'(N));
         if (cmd.scan_start) cnt_ff <= '0;
         else if (cmd.scan_step && cnt_ff < CW'(N)) cnt_ff <= cnt_ff + CW'(1);
         valid_ff <= valid_in;
      end
   end

endmodule

// File: sv/lbf_csr.sv
// lbf_csr: apb-style configuration registers
// depends on lbf_pkg
`timescale 1ns / 1ps

module lbf_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        learn_en,
   output logic [31:0] expiry_ticks,
   output logic [47:0] bridge_mac,
   output logic [7:0]  port_mask
);

   logic        learn_en_ff;
   logic [31:0] expiry_ff;
   logic [47:0] bridge_ff;
   logic [7:0]  ports_ff;
   logic [1:0]  reg_idx;

   assign reg_idx      = paddr[4:3];
   assign learn_en     = learn_en_ff;
   assign expiry_ticks = expiry_ff;
   assign bridge_mac   = bridge_ff;
   assign port_mask    = ports_ff;

   // read mux
   always_comb begin
      unique case (reg_idx)
         lbf_pkg::RegLearnEn: prdata = {63'd0, learn_en_ff};
         lbf_pkg::RegExpiry:  prdata = {32'd0, expiry_ff};
         lbf_pkg::RegBridge:  prdata = {16'd0, bridge_ff};
         lbf_pkg::RegPorts:   prdata = {56'd0, ports_ff};
         default:             prdata = '0;
      endcase
   end

   // write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         learn_en_ff <= 1'b1;
         expiry_ff   <= lbf_pkg::DefaultExpiry;
         bridge_ff   <= '0;
         ports_ff    <= '0;
      end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
         unique case (reg_idx)
            lbf_pkg::RegLearnEn: learn_en_ff <= pwdata[0];
            lbf_pkg::RegExpiry:  expiry_ff   <= pwdata[31:0];
            lbf_pkg::RegBridge:  bridge_ff   <= pwdata[47:0];
            lbf_pkg::RegPorts:   ports_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

endmodule

// File: sv/lbf_checker.sv
// lbf_checker: port-level assertions for the learning bridge, with bind
// depends on learning_bridge_forwarder_top
`timescale 1ns / 1ps

module lbf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_port_mask,
   input logic       rsp_flooded,
   input logic       rsp_deliver_up
);

   // a pending response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");

   // no request taken the cycle after one was taken
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("overlap");

   // a forwarded unicast goes to exactly one port
   a_unicast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_flooded && rsp_tx_port_mask != 8'd0 |->
      $onehot(rsp_tx_port_mask)) else $error("unicast mask");

   // delivered-up unflooded frames go nowhere else
   a_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deliver_up && !rsp_flooded |-> rsp_tx_port_mask == 8'd0)
      else $error("local mask");

endmodule

bind learning_bridge_forwarder_top lbf_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_tx_port_mask(rsp.data.tx_port_mask),
   .rsp_flooded(rsp.data.flooded),
   .rsp_deliver_up(rsp.data.deliver_up)
);

// File: bench/learning_bridge_forwarder_top_tb.sv
// learning_bridge_forwarder_top_tb: self-checking bench for the learning bridge forwarder
// depends on lbf_pkg, lbf_if and learning_bridge_forwarder_top
`timescale 1ns / 1ps

module learning_bridge_forwarder_top_tb;

   typedef struct packed {
      logic                        cmd;
      logic [lbf_pkg::MacW-1:0]    src_mac;
      logic [lbf_pkg::MacW-1:0]    dst_mac;
      logic [lbf_pkg::PortW-1:0]   in_port;
      logic [1:0]                  frame_kind;
      logic [lbf_pkg::TimeW-1:0]   now;
   } frame_hdr_type;

   typedef struct packed {
      logic                        deliver_up;
      logic [lbf_pkg::MaskW-1:0]   tx_port_mask;
      logic                        flooded;
   } fwd_result_type;

   typedef struct {
      frame_hdr_type  hdr;
      bit             typed;
      fwd_result_type want;
   } dir_row_type;

   localparam logic CmdRx = 1'b0;
   localparam logic CmdTx = 1'b1;
   localparam int   CycleLimit = 2000000;
   localparam int   DrainCycles = 80;
   localparam int   PhaseItems = 290;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   lbf_if #(.payload_type(frame_hdr_type))  req_ch ();
   lbf_if #(.payload_type(fwd_result_type)) rsp_ch ();

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   learning_bridge_forwarder_top dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the bridge configuration and mac table
   logic                        sh_learn_en;
   logic [31:0]                 sh_lifetime;
   logic [lbf_pkg::MacW-1:0]    sh_bridge_mac;
   logic [lbf_pkg::MaskW-1:0]   sh_ports;
   logic                        tbl_valid  [lbf_pkg::TableEntries];
   logic [lbf_pkg::MacW-1:0]    tbl_mac    [lbf_pkg::TableEntries];
   logic [lbf_pkg::PortW-1:0]   tbl_port   [lbf_pkg::TableEntries];
   logic [lbf_pkg::TimeW-1:0]   tbl_expiry [lbf_pkg::TableEntries];

   fwd_result_type pending_results[$];
   int  mismatches = 0;
   int  frames_sent = 0;
   int  results_seen = 0;
   int  csr_writes = 0;
   bit  quiet = 1'b0;
   bit  long_hold = 1'b0;
   int  cycles = 0;

   // random 48-bit mac
   function automatic logic [lbf_pkg::MacW-1:0] rand_mac();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[lbf_pkg::MacW-1:0];
   endfunction

   // learn a source mac on the shadow table
   function automatic void learn_mac(logic [lbf_pkg::MacW-1:0] mac,
                                     logic [lbf_pkg::PortW-1:0] port,
                                     logic [lbf_pkg::TimeW-1:0] now);
      int slot;
      logic [32:0] sum;
      slot = -1;
      if (!sh_learn_en) return;
      for (int i = 0; i < lbf_pkg::TableEntries; i++)
         if (slot < 0 && tbl_valid[i] && tbl_mac[i] == mac) slot = i;
      for (int i = 0; i < lbf_pkg::TableEntries; i++)
         if (slot < 0 && !tbl_valid[i]) slot = i;
      if (slot < 0) begin
         slot = 0;
         for (int i = 1; i < lbf_pkg::TableEntries; i++)
            if (tbl_expiry[i] < tbl_expiry[slot]) slot = i;
      end
      sum = {1'b0, now} + {1'b0, sh_lifetime};
      tbl_valid[slot]  = 1'b1;
      tbl_mac[slot]    = mac;
      tbl_port[slot]   = port;
      tbl_expiry[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // live port for a mac, or -1; stale matches are erased
   function automatic int find_port(logic [lbf_pkg::MacW-1:0] mac,
                                    logic [lbf_pkg::TimeW-1:0] now);
      if (!sh_learn_en) return -1;
      for (int i = 0; i < lbf_pkg::TableEntries; i++)
         if (tbl_valid[i] && tbl_mac[i] == mac) begin
            if (tbl_expiry[i] > now) return int'(tbl_port[i]);
            tbl_valid[i] = 1'b0;
            return -1;
         end
      return -1;
   endfunction

   // forwarding decision for one frame header
   function automatic fwd_result_type forward_frame(frame_hdr_type h);
      fwd_result_type r;
      logic [lbf_pkg::MaskW-1:0] usable;
      logic [lbf_pkg::MaskW-1:0] others;
      int p;
      r = '0;
      usable = sh_ports & lbf_pkg::UsableLim;
      others = usable & ~(8'd1 << h.in_port);
      if (h.cmd == CmdTx) begin
         p = -1;
         if (!h.dst_mac[lbf_pkg::GroupBit]) p = find_port(h.dst_mac, h.now);
         if (p >= 0 && usable[p]) r.tx_port_mask = 8'd1 << p;
         else begin
            r.tx_port_mask = usable;
            r.flooded = 1'b1;
         end
      end else if (h.frame_kind == lbf_pkg::KindBcast || h.frame_kind == lbf_pkg::KindMcast) begin
         learn_mac(h.src_mac, h.in_port, h.now);
         r.deliver_up = 1'b1;
         r.tx_port_mask = others;
         r.flooded = 1'b1;
      end else if (h.dst_mac == sh_bridge_mac) begin
         learn_mac(h.src_mac, h.in_port, h.now);
         r.deliver_up = 1'b1;
      end else if (h.frame_kind == lbf_pkg::KindOther) begin
         learn_mac(h.src_mac, h.in_port, h.now);
         p = find_port(h.dst_mac, h.now);
         if (p >= 0 && p != int'(h.in_port) && usable[p]) r.tx_port_mask = 8'd1 << p;
         else begin
            r.tx_port_mask = others;
            r.flooded = 1'b1;
         end
      end
      return r;
   endfunction

   // apb register write, setup then access, then read back
   task automatic csr_write(logic [1:0] idx, logic [63:0] value);
      logic [63:0] back;
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         lbf_pkg::RegLearnEn: begin
            sh_learn_en = value[0];
            back = {63'd0, value[0]};
         end
         lbf_pkg::RegExpiry: begin
            sh_lifetime = value[31:0];
            back = {32'd0, value[31:0]};
         end
         lbf_pkg::RegBridge: begin
            sh_bridge_mac = value[47:0];
            back = {16'd0, value[47:0]};
         end
         lbf_pkg::RegPorts: begin
            sh_ports = value[7:0];
            back = {56'd0, value[7:0]};
         end
         default: back = '0;
      endcase
      csr_writes++;
      @(posedge clock);
      if (csr_pready !== 1'b1 || csr_prdata !== back) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d: expected %h got %h ready=%0b",
                     idx, back, csr_prdata, csr_pready);
      end
   endtask

   // let the block drain before touching registers
   task automatic wait_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(logic en, logic [31:0] life, logic [47:0] mac, logic [7:0] ports);
      wait_idle();
      csr_write(lbf_pkg::RegLearnEn, {63'd0, en});
      csr_write(lbf_pkg::RegExpiry, {32'd0, life});
      csr_write(lbf_pkg::RegBridge, {16'd0, mac});
      csr_write(lbf_pkg::RegPorts, {56'd0, ports});
   endtask

   // offer one transaction and wait until it is taken
   task automatic send_frame(frame_hdr_type h, bit typed, fwd_result_type want);
      fwd_result_type got;
      fwd_result_type owed;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= h;
      do @(posedge clock); while (!req_ch.ready);
      got = forward_frame(h);
      owed = typed ? want : got;
      pending_results = {pending_results, owed};
      frames_sent++;
   endtask

   // receiver side ready, with random stalls and one long hold-off
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      fwd_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
         end else begin
            exp_r = pending_results[0];
            pending_results.delete(0);
            if (rsp_ch.data.deliver_up !== exp_r.deliver_up
                || rsp_ch.data.tx_port_mask !== exp_r.tx_port_mask
                || rsp_ch.data.flooded !== exp_r.flooded) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: expected up=%0b tx=%02h fl=%0b %s",
                           results_seen, exp_r.deliver_up, exp_r.tx_port_mask,
                           exp_r.flooded, "got:");
               if (mismatches <= 10)
                  $display("   up=%0b tx=%02h fl=%0b", rsp_ch.data.deliver_up,
                           rsp_ch.data.tx_port_mask, rsp_ch.data.flooded);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // random frame from a small mac pool so learning and lookup hit
   function automatic frame_hdr_type random_frame(logic [lbf_pkg::MacW-1:0] pool[16],
                                                  logic [lbf_pkg::TimeW-1:0] now);
      frame_hdr_type h;
      int pick;
      h.cmd        = ($urandom_range(0, 3) == 0) ? CmdTx : CmdRx;
      h.in_port    = 3'($urandom_range(0, 7));
      h.frame_kind = 2'($urandom_range(0, 3));
      h.now        = now;
      h.src_mac    = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 15)] : rand_mac();
      pick = $urandom_range(0, 19);
      if (pick < 12)      h.dst_mac = pool[$urandom_range(0, 15)];
      else if (pick < 15) h.dst_mac = sh_bridge_mac;
      else if (pick < 17) h.dst_mac = 48'hFFFF_FFFF_FFFF;
      else                h.dst_mac = rand_mac();
      return h;
   endfunction

   // main sequence
   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      logic [lbf_pkg::MacW-1:0] pool[16];
      logic [lbf_pkg::TimeW-1:0] now;
      logic [lbf_pkg::TimeW-1:0] bases[6];
      logic [31:0] lifes[6];
      logic [7:0]  portsets[6];
      logic        ens[6];

      for (int i = 0; i < lbf_pkg::TableEntries; i++) tbl_valid[i] = 1'b0;
      sh_learn_en = 1'b1; sh_lifetime = lbf_pkg::DefaultExpiry;
      sh_bridge_mac = '0; sh_ports = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, reset configuration except all ports attached
      csr_write(lbf_pkg::RegPorts, 64'hFF);
      row.typed = 1'b1;
      row.hdr = '{CmdRx, 48'h0000_0000_0001, 48'h0, 3'd0, lbf_pkg::KindHost, 32'd10};
      row.want = '{1'b1, 8'h00, 1'b0}; rows = {rows, row};
      row.hdr = '{CmdRx, 48'h0000_0000_0002, 48'h1234_5678_9ABC, 3'd1, lbf_pkg::KindHost,
                  32'd11};
      row.want = '{1'b0, 8'h00, 1'b0}; rows = {rows, row};
      row.hdr = '{CmdRx, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd7, lbf_pkg::KindBcast,
                  32'd12};
      row.want = '{1'b1, 8'h7F, 1'b1}; rows = {rows, row};
      row.hdr = '{CmdRx, 48'h0000_0000_0003, 48'h0100_5E00_0001, 3'd3, lbf_pkg::KindMcast,
                  32'd13};
      row.want = '{1'b1, 8'hF7, 1'b1}; rows = {rows, row};
      row.hdr = '{CmdTx, 48'h0, 48'hFFFF_FFFF_FFFF, 3'd0, lbf_pkg::KindHost, 32'd14};
      row.want = '{1'b0, 8'hFF, 1'b1}; rows = {rows, row};
      row.typed = 1'b0;
      row.hdr = '{CmdRx, 48'h0000_0000_0004, 48'h0000_0000_0001, 3'd5, lbf_pkg::KindOther,
                  32'd15};
      rows = {rows, row};
      row.hdr = '{CmdTx, 48'h0, 48'h0000_0000_0004, 3'd0, lbf_pkg::KindHost, 32'd16};
      rows = {rows, row};
      row.hdr = '{CmdRx, 48'h0000_0000_0001, 48'h0000_0000_0003, 3'd3, lbf_pkg::KindOther,
                  32'd17};
      rows = {rows, row};
      row.hdr = '{CmdRx, 48'h0000_0000_0005, 48'h0000_0000_0004, 3'd2, lbf_pkg::KindOther,
                  32'd400};
      rows = {rows, row};
      row.hdr = '{CmdTx, 48'h0, 48'h0000_0000_0001, 3'd0, lbf_pkg::KindOther, 32'hFFFF_FFFF};
      rows = {rows, row};
      row.hdr = '{CmdRx, 48'h0000_0000_0006, 48'h0, 3'd4, lbf_pkg::KindOther, 32'hFFFF_FFF0};
      rows = {rows, row};
      row.hdr = '{CmdTx, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0006, 3'd7, lbf_pkg::KindMcast,
                  32'hFFFF_FFF1};
      rows = {rows, row};
      foreach (rows[i]) send_frame(rows[i].hdr, rows[i].typed, rows[i].want);
      req_ch.valid <= 1'b0;

      // random phases: settings sweep, the last one without idling
      ens      = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      lifes    = '{32'd300, 32'd20, 32'd50, 32'hFFFF_FFFF, 32'd0, 32'd40};
      portsets = '{8'hFF, 8'h5A, 8'h00, 8'hA5, 8'hFF, 8'h3C};
      bases    = '{32'd1000, 32'd50000, 32'h8000_0000, 32'hFFFF_F000, 32'h1000, 32'h7FFF_0000};
      for (int ph = 0; ph < 6; ph++) begin
         set_config(ens[ph], lifes[ph], rand_mac(), portsets[ph]);
         foreach (pool[k]) pool[k] = rand_mac();
         pool[0] = sh_bridge_mac;
         now = bases[ph];
         quiet = (ph == 5);
         if (ph == 1) long_hold = 1'b1;
         for (int n = 0; n < PhaseItems; n++) begin
            if ($urandom_range(0, 1)) now = now + $urandom_range(0, 9);
            send_frame(random_frame(pool, now), 1'b0, '0);
         end
         req_ch.valid <= 1'b0;
      end

      wait_idle();
      $display("sent %0d frames, checked %0d results, %0d register writes over six settings",
               frames_sent, results_seen, csr_writes);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("mismatches %0d, results still owed %0d", mismatches, pending_results.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
